// ===== rtl/csma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csma_pkg;

  // Default depth of the send queue and the fixed length of a bus frame.
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int FRAME_BITS      = 10;
  localparam logic [3:0] FRAME_BITS_IDX = 4'(FRAME_BITS);

  // Configuration register indexes and their reset values.
  localparam logic CFG_CARRIER   = 1'b0;
  localparam logic CFG_COLLISION = 1'b1;
  localparam logic [7:0] CARRIER_TICKS_RST   = 8'd20;
  localparam logic [7:0] COLLISION_TICKS_RST = 8'd15;

  // Request kinds.
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_SEND = 2'd2;

  // Answers to a send request.
  localparam logic [2:0] SEND_NONE     = 3'd0;
  localparam logic [2:0] SEND_ACCEPTED = 3'd1;
  localparam logic [2:0] SEND_CD_BACK  = 3'd2;
  localparam logic [2:0] SEND_PRIO     = 3'd3;
  localparam logic [2:0] SEND_BUSY     = 3'd4;
  localparam logic [2:0] SEND_FULL     = 3'd5;
  localparam logic [2:0] SEND_DROPPED  = 3'd6;

  // Transmission outcomes.
  localparam logic [1:0] TXO_NONE = 2'd0;
  localparam logic [1:0] TXO_DONE = 2'd1;
  localparam logic [1:0] TXO_COLL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RX   = 3'd1,
    ST_CD   = 3'd2,
    ST_TX   = 3'd3,
    ST_COLL = 3'd4
  } bus_state_t;

  // Operations on the send queue for one request.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } q_ctl_t;

  // One result.
  typedef struct packed {
    logic        line_drive;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic [2:0]  send_status;
    logic [1:0]  tx_outcome;
    logic [2:0]  bus_state;
    logic [15:0] collision_count;
  } result_t;

  // Start bit low, eight data bits LSB first, stop bit high.
  function automatic logic [FRAME_BITS-1:0] frame_of(input logic [7:0] b);
    frame_of = {1'b1, b, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csma_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one bus event or send offer per transfer.
interface csma_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       line_active;
  logic [7:0] prio_delay;
  logic       last_of_packet;

  modport source (output valid, mode, data_byte, line_active, prio_delay, last_of_packet,
                  input ready);
  modport sink (input valid, mode, data_byte, line_active, prio_delay, last_of_packet,
                output ready);
endinterface

// Result channel: one result per request.
interface csma_out_if;
  logic        valid;
  logic        ready;
  logic        line_drive;
  logic        rx_valid;
  logic [7:0]  rx_data;
  logic [2:0]  send_status;
  logic [1:0]  tx_outcome;
  logic [2:0]  bus_state;
  logic [15:0] collision_count;

  modport source (output valid, line_drive, rx_valid, rx_data, send_status, tx_outcome,
                  bus_state, collision_count, input ready);
  modport sink (input valid, line_drive, rx_valid, rx_data, send_status, tx_outcome,
                bus_state, collision_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/csma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/csma_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csma_queue
  import csma_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire q_ctl_t                         ctl,
  output      logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
  output      logic [7:0]                     head_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count_next;
  logic          wr_en;
  logic [7:0]    ram_q;
  logic          fwd_valid;
  logic [7:0]    fwd_data;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign wr_en = ctl.push && !ctl.clear;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (ctl.clear) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end else begin
      if (ctl.pop) begin
        head_next = wrap_inc(head);
      end
      if (ctl.push) begin
        tail_next = wrap_inc(tail);
      end
      if (ctl.push && !ctl.pop) begin
        count_next = count + CW'(1);
      end else if (ctl.pop && !ctl.push) begin
        count_next = count - CW'(1);
      end
    end
  end

  // The head entry is read every cycle, so its byte is ready when a load needs it.
  csma_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (ctl.wdata),
    .raddr (head_next),
    .rdata (ram_q)
  );

  // A write to the entry being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      fwd_valid <= wr_en && (tail == head_next);
    end
    fwd_data <= ctl.wdata;
  end

  assign head_data = fwd_valid ? fwd_data : ram_q;

endmodule

`default_nettype wire

// ===== rtl/csma_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csma_out_buf
  import csma_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t din,
  output      logic    ready,
  csma_out_if.source   out_ch
);

  result_t q0, q1;
  logic    v0, v1;
  logic    pop;

  assign pop   = v0 && out_ch.ready;
  assign ready = !v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (push && !pop) begin
        if (!v0) begin
          v0 <= 1'b1;
        end else begin
          v1 <= 1'b1;
        end
      end else if (pop && !push) begin
        v0 <= v1;
        v1 <= 1'b0;
      end
    end
    if (push && !pop) begin
      if (!v0) begin
        q0 <= din;
      end else begin
        q1 <= din;
      end
    end else if (pop && !push) begin
      q0 <= q1;
    end else if (pop && push) begin
      if (v1) begin
        q0 <= q1;
        q1 <= din;
      end else begin
        q0 <= din;
      end
    end
  end

  assign out_ch.valid           = v0;
  assign out_ch.line_drive      = q0.line_drive;
  assign out_ch.rx_valid        = q0.rx_valid;
  assign out_ch.rx_data         = q0.rx_data;
  assign out_ch.send_status     = q0.send_status;
  assign out_ch.tx_outcome      = q0.tx_outcome;
  assign out_ch.bus_state       = q0.bus_state;
  assign out_ch.collision_count = q0.collision_count;

endmodule

`default_nettype wire

// ===== rtl/csma_cd_byte_bus_access.sv =====
// Media access controller for a shared single-wire byte bus with collision
// detection by echo check.
// Requests arrive on in_ch: a bit-time tick (with the sampled line level), a
// byte received from the bus, or a byte offered for sending. Each accepted
// request produces exactly one result on out_ch, carrying the line drive level,
// any forwarded received byte, the answer to a send offer, the transmission
// outcome, the bus state and the running collision count.
// A result is registered into the output buffer and shown on out_ch once it
// is the oldest entry there. One request is accepted per cycle while the buffer
// has room; the state update of a request completes in its own cycle, and the
// send queue memory is read ahead at the next head address every cycle, with a
// bypass for a same-cycle write there, so a load never waits on the memory.
// Results pass through a two-entry output buffer. When the receiver stalls,
// requests keep being accepted until both entries hold results; ready then
// stays low until the cycle after the receiver takes one.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at the next
// edge and are meant to be made while no request is in progress.
// Synchronous reset returns the bus to idle, empties the send queue, clears the
// collision count and restores carrier_ticks to 20 and collision_ticks to 15.
// No clearing pass is needed: queue entries are only read after being written.
`timescale 1ns / 1ps
`default_nettype none

module csma_cd_byte_bus_access
  import csma_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  csma_in_if.sink         in_ch,
  csma_out_if.source      out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [7:0] carrier_ticks;
  logic [7:0] collision_ticks;

  // Bus state and transmit shifter.
  bus_state_t            bus_mode, bus_mode_next;
  logic [7:0]            ticks, ticks_next;
  logic [FRAME_BITS-1:0] frame, frame_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            byte_in_flight, byte_in_flight_next;
  logic                  awaiting_echo, awaiting_echo_next;
  logic                  packet_open, packet_open_next;
  logic [15:0]           collisions, collisions_next;

  // Send queue.
  q_ctl_t     q_ctl;
  logic [CW-1:0] q_count;
  logic [7:0] q_head;
  logic       q_full;
  logic       q_nonempty;

  logic    in_acc;
  logic    buf_ready;
  result_t res;

  // Per-request decisions.
  logic                  do_coll;
  logic                  do_load;
  logic                  go;
  logic [3:0]            tap_sel;
  logic [FRAME_BITS-1:0] tap_word;

  assign in_ch.ready = buf_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign q_full      = (q_count == CW'(QUEUE_DEPTH));
  assign q_nonempty  = (q_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_ticks   <= CARRIER_TICKS_RST;
      collision_ticks <= COLLISION_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CARRIER:   carrier_ticks   <= cfg_data;
        CFG_COLLISION: collision_ticks <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode       <= ST_IDLE;
      ticks          <= '0;
      frame          <= '1;
      bit_index      <= FRAME_BITS_IDX;
      byte_in_flight <= '0;
      awaiting_echo  <= 1'b0;
      packet_open    <= 1'b0;
      collisions     <= '0;
    end else begin
      bus_mode       <= bus_mode_next;
      ticks          <= ticks_next;
      frame          <= frame_next;
      bit_index      <= bit_index_next;
      byte_in_flight <= byte_in_flight_next;
      awaiting_echo  <= awaiting_echo_next;
      packet_open    <= packet_open_next;
      collisions     <= collisions_next;
    end
  end

  always_comb begin
    bus_mode_next       = bus_mode;
    ticks_next          = ticks;
    frame_next          = frame;
    bit_index_next      = bit_index;
    byte_in_flight_next = byte_in_flight;
    awaiting_echo_next  = awaiting_echo;
    packet_open_next    = packet_open;
    collisions_next     = collisions;
    q_ctl               = '0;
    q_ctl.wdata         = in_ch.data_byte;
    do_coll             = 1'b0;
    do_load             = 1'b0;
    go                  = 1'b0;
    res                 = '0;
    tap_sel             = '0;
    tap_word            = '0;

    if (in_acc) begin
      unique case (in_ch.mode)
        MODE_TICK: begin
          if (ticks != 8'hFF) begin
            ticks_next = ticks + 8'd1;
          end
          unique case (bus_mode)
            ST_RX: begin
              bus_mode_next = ST_CD;
              ticks_next    = '0;
            end
            ST_CD: begin
              if (ticks_next >= carrier_ticks) begin
                bus_mode_next = ST_IDLE;
                ticks_next    = '0;
              end
            end
            ST_COLL: begin
              if (ticks_next >= collision_ticks) begin
                bus_mode_next = ST_CD;
                ticks_next    = '0;
              end
            end
            ST_TX: begin
              if (bit_index < FRAME_BITS_IDX) begin
                bit_index_next = bit_index + 4'd1;
              end
            end
            default: begin
              // Idle: start a complete packet; if someone already holds the line, count a collision.
              if (q_nonempty && !packet_open) begin
                if (in_ch.line_active) begin
                  do_coll = 1'b1;
                end else begin
                  bus_mode_next = ST_TX;
                  ticks_next    = '0;
                  do_load       = 1'b1;
                end
              end
            end
          endcase
        end
        MODE_RX: begin
          if (bus_mode == ST_TX) begin
            // While transmitting, every received byte is our own echo.
            if (awaiting_echo && (in_ch.data_byte != byte_in_flight)) begin
              do_coll = 1'b1;
            end else if (q_nonempty) begin
              do_load = 1'b1;
            end else begin
              bit_index_next     = FRAME_BITS_IDX;
              frame_next         = '1;
              awaiting_echo_next = 1'b0;
              bus_mode_next      = ST_CD;
              ticks_next         = '0;
              res.tx_outcome     = TXO_DONE;
            end
          end else begin
            res.rx_valid  = 1'b1;
            res.rx_data   = in_ch.data_byte;
            bus_mode_next = ST_RX;
            ticks_next    = '0;
          end
        end
        MODE_SEND: begin
          if (!packet_open) begin
            if (bus_mode == ST_CD) begin
              // Priority window: an early first byte cuts the backoff short.
              if (ticks < in_ch.prio_delay) begin
                bus_mode_next = ST_IDLE;
                ticks_next    = '0;
                go            = 1'b1;
              end else if (ticks < carrier_ticks) begin
                res.send_status = SEND_CD_BACK;
              end else begin
                res.send_status = SEND_PRIO;
              end
            end else if (bus_mode == ST_IDLE) begin
              go = 1'b1;
            end else begin
              res.send_status = SEND_BUSY;
            end
            if (go) begin
              if (!q_full) begin
                q_ctl.push       = 1'b1;
                res.send_status  = SEND_ACCEPTED;
                packet_open_next = !in_ch.last_of_packet;
              end else begin
                res.send_status = SEND_FULL;
              end
            end
          end else begin
            if ((bus_mode == ST_IDLE) || (bus_mode == ST_TX)) begin
              if (!q_full) begin
                q_ctl.push      = 1'b1;
                res.send_status = SEND_ACCEPTED;
              end else begin
                res.send_status = SEND_FULL;
              end
            end else begin
              res.send_status = SEND_DROPPED;
            end
            packet_open_next = !in_ch.last_of_packet;
          end
        end
        default: ;
      endcase

      if (do_coll) begin
        collisions_next    = collisions + 16'd1;
        q_ctl.clear        = 1'b1;
        bit_index_next     = FRAME_BITS_IDX;
        frame_next         = '1;
        awaiting_echo_next = 1'b0;
        bus_mode_next      = ST_COLL;
        ticks_next         = '0;
        res.tx_outcome     = TXO_COLL;
      end

      if (do_load) begin
        q_ctl.pop           = 1'b1;
        frame_next          = frame_of(q_head);
        bit_index_next      = '0;
        byte_in_flight_next = q_head;
        awaiting_echo_next  = 1'b1;
      end
    end

    // Line drive follows the state after the request.
    if (bus_mode_next == ST_COLL) begin
      res.line_drive = 1'b1;
    end else if ((bus_mode_next == ST_TX) && (bit_index_next != '0)) begin
      tap_sel        = bit_index_next - 4'd1;
      tap_word       = frame_next >> tap_sel;
      res.line_drive = ~tap_word[0];
    end
    res.bus_state       = bus_mode_next;
    res.collision_count = collisions_next;
  end

  csma_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (q_ctl),
    .count     (q_count),
    .head_data (q_head)
  );

  csma_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (in_acc),
    .din    (res),
    .ready  (buf_ready),
    .out_ch (out_ch)
  );

  // A collision empties the queue and puts the bus in the collision state.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && (res.tx_outcome == TXO_COLL)) |=> ((q_count == '0) && (bus_mode == ST_COLL)))
    else $error("collision did not clear the queue");

  // An echo is only ever expected while transmitting.
  assert property (@(posedge clk) disable iff (rst)
    awaiting_echo |-> (bus_mode == ST_TX))
    else $error("echo pending outside transmit");

  // Requests are refused only while results wait in the output buffer.
  assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("request refused with empty output buffer");

endmodule

`default_nettype wire
